// File: design/stt_pkg.sv
package stt_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int LINE_BITS = 24;
	localparam int COLUMN_BITS = 16;
	localparam int LEN_BITS = 16;

	// token kinds
	localparam logic [3:0] K_SPACE = 4'd0;
	localparam logic [3:0] K_EOL = 4'd1;
	localparam logic [3:0] K_CHAR = 4'd2;
	localparam logic [3:0] K_STRING = 4'd3;
	localparam logic [3:0] K_INT = 4'd4;
	localparam logic [3:0] K_LABEL = 4'd5;
	localparam logic [3:0] K_VAR = 4'd6;
	localparam logic [3:0] K_IDENT = 4'd7;
	localparam logic [3:0] K_OTHER = 4'd8;
	localparam logic [3:0] K_ERROR = 4'd9;
	localparam logic [3:0] K_EOF = 4'd10;

	// scan modes
	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_SPACE = 4'd1;
	localparam logic [3:0] M_CHAR = 4'd2;
	localparam logic [3:0] M_STRING = 4'd3;
	localparam logic [3:0] M_INT = 4'd4;
	localparam logic [3:0] M_LABEL = 4'd5;
	localparam logic [3:0] M_VAR = 4'd6;
	localparam logic [3:0] M_IDENT = 4'd7;
	localparam logic [3:0] M_COMMENT = 4'd8;

	typedef struct packed {
		logic [3:0] kind;
		logic [OFFSET_BITS-1:0] ofs;
		logic [LEN_BITS-1:0] len;
		logic [LINE_BITS-1:0] line;
		logic [COLUMN_BITS-1:0] col;
		logic [63:0] value;
		logic last;
	} token_t;

	// one queue entry: up to two tokens caused by one byte
	typedef struct packed {
		logic two;
		token_t first;
		token_t second;
	} pair_t;

endpackage

// File: design/source_text_tokenizer_unit.sv
// Byte-stream tokenizer. Takes one source byte (or the end flag) per cycle when
// the output keeps up; a byte that closes one token and opens another gives two
// output words, which leave one at a time on the master side, so sustained rate is
// one byte per cycle, dropping while two-token bytes drain the two-entry queue.
module source_text_tokenizer_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // data_byte
	input logic s_tuser, // is_end
	output logic m_tvalid,
	input logic m_tready,
	// token_kind, start_offset, token_length, start_line, start_column, token_value
	output logic [159:0] m_tdata,
	output logic m_tlast
);

	logic pv, pr;
	stt_pkg::pair_t pair;
	stt_pkg::token_t tok;

	stt_scan u_scan (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.data_byte(s_tdata), .is_end(s_tuser), .pair_valid(pv), .pair_ready(pr), .pair);

	stt_emit u_emit (.clk, .arst_n, .pair_valid(pv), .pair_ready(pr), .pair,
		.tok_valid(m_tvalid), .tok_ready(m_tready), .tok);

	// pack output word
	assign m_tdata = {4'd0, tok.value, tok.col, tok.line, tok.len, tok.ofs, tok.kind};
	assign m_tlast = tok.last;

endmodule

// File: design/stt_scan.sv
module stt_scan (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic is_end,
	output logic pair_valid,
	input logic pair_ready,
	output stt_pkg::pair_t pair
);

	logic [3:0] mode_q;
	logic [1:0] phase_q;
	logic esc_q, hex_q;
	logic [7:0] held_q;
	logic [63:0] acc_q;
	logic [stt_pkg::OFFSET_BITS-1:0] tstart_q, pos_q;
	logic [stt_pkg::LEN_BITS-1:0] len_q;
	logic [stt_pkg::LINE_BITS-1:0] tline_q, line_q;
	logic [stt_pkg::COLUMN_BITS-1:0] tcol_q, col_q;
	logic valid_q;
	stt_pkg::pair_t pair_q;

	logic [3:0] mode_d;
	logic [1:0] phase_d;
	logic esc_d, hex_d;
	logic [7:0] held_d;
	logic [63:0] acc_d;
	logic [stt_pkg::OFFSET_BITS-1:0] tstart_d;
	logic [stt_pkg::LEN_BITS-1:0] len_d;
	logic [stt_pkg::LINE_BITS-1:0] tline_d;
	logic [stt_pkg::COLUMN_BITS-1:0] tcol_d;
	logic [1:0] cnt;
	stt_pkg::token_t t0, t1;
	logic taken;
	logic [7:0] b;
	logic dig, alpha, idch, hexc;
	logic [3:0] hv;
	logic [stt_pkg::LEN_BITS-1:0] len_inc;

	assign in_ready = !valid_q || pair_ready;
	assign pair_valid = valid_q;
	assign pair = pair_q;

	assign b = data_byte;
	assign dig = b >= 8'h30 && b <= 8'h39;
	assign alpha = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
	assign idch = alpha || dig;
	assign hexc = dig || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
	assign hv = dig ? b[3:0] : 4'(b[2:0] + 3'd1) + 4'd8;
	assign len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

	function automatic stt_pkg::token_t mk(input logic [3:0] k,
			input logic [stt_pkg::OFFSET_BITS-1:0] o, input logic [stt_pkg::LEN_BITS-1:0] l,
			input logic [stt_pkg::LINE_BITS-1:0] ln, input logic [stt_pkg::COLUMN_BITS-1:0] c,
			input logic [63:0] v);
		stt_pkg::token_t t;
		t.kind = k; t.ofs = o; t.len = l; t.line = ln; t.col = c; t.value = v; t.last = 1'b0;
		return t;
	endfunction

	// per-byte classification and token assembly
	always_comb begin
		logic fin;
		stt_pkg::token_t ft;
		logic fe;
		fin = 1'b0;
		fe = 1'b0;
		ft = mk(stt_pkg::K_ERROR, tstart_q, len_q, tline_q, tcol_q, 64'd0);
		mode_d = mode_q; phase_d = phase_q; esc_d = esc_q; hex_d = hex_q;
		held_d = held_q; acc_d = acc_q; tstart_d = tstart_q; len_d = len_q;
		tline_d = tline_q; tcol_d = tcol_q;
		cnt = 2'd0; t0 = ft; t1 = ft;
		taken = 1'b0;
		// finishing a pending token
		unique case (mode_q)
			stt_pkg::M_SPACE: begin ft.kind = stt_pkg::K_SPACE; fe = 1'b1; end
			stt_pkg::M_CHAR, stt_pkg::M_STRING: fe = 1'b1;
			stt_pkg::M_INT: begin ft.kind = stt_pkg::K_INT; ft.value = acc_q; fe = 1'b1; end
			stt_pkg::M_LABEL: begin
				fe = 1'b1;
				if (len_q > 16'd1) begin ft.kind = stt_pkg::K_LABEL; ft.value = acc_q; end
				else begin ft.kind = stt_pkg::K_OTHER; ft.value = 64'h40; end
			end
			stt_pkg::M_VAR: begin
				fe = 1'b1;
				ft.kind = (len_q > 16'd1) ? stt_pkg::K_VAR : stt_pkg::K_OTHER;
				ft.value = {56'd0, held_q};
			end
			stt_pkg::M_IDENT: begin ft.kind = stt_pkg::K_IDENT; fe = 1'b1; end
			default: fe = 1'b0;
		endcase
		if (is_end) begin
			if (fe) begin t0 = ft; cnt = 2'd1; end
			if (fe) t1 = mk(stt_pkg::K_EOF, pos_q, '0, line_q, col_q, 64'd0);
			else t0 = mk(stt_pkg::K_EOF, pos_q, '0, line_q, col_q, 64'd0);
			cnt = cnt + 2'd1;
		end else begin
			// offer byte to pending token
			unique case (mode_q)
				stt_pkg::M_SPACE: if (b == 8'h20) begin taken = 1'b1; len_d = len_inc; end
					else fin = 1'b1;
				stt_pkg::M_CHAR: begin
					if (phase_q == 2'd1) begin
						taken = 1'b1; len_d = len_inc;
						if (b == 8'h5c) phase_d = 2'd2;
						else begin held_d = b; phase_d = 2'd3; end
					end else if (phase_q == 2'd2) begin
						taken = 1'b1; len_d = len_inc; phase_d = 2'd3;
						priority case (b)
							8'h30: held_d = 8'd0;
							8'h6e: held_d = 8'd10;
							8'h72: held_d = 8'd13;
							8'h74: held_d = 8'd9;
							default: held_d = b;
						endcase
					end else if (b == 8'h27) begin
						taken = 1'b1; len_d = len_inc;
						t0 = mk(stt_pkg::K_CHAR, tstart_q, len_inc, tline_q, tcol_q,
							{56'd0, held_q});
						cnt = 2'd1; mode_d = stt_pkg::M_IDLE; phase_d = 2'd0;
					end else begin phase_d = 2'd0; fin = 1'b1; end
				end
				stt_pkg::M_STRING: begin
					if (esc_q) begin taken = 1'b1; len_d = len_inc; esc_d = 1'b0; end
					else if (b == 8'h5c) begin taken = 1'b1; len_d = len_inc; esc_d = 1'b1; end
					else if (b == 8'h22) begin
						taken = 1'b1; len_d = len_inc;
						t0 = mk(stt_pkg::K_STRING, tstart_q, len_inc, tline_q, tcol_q, 64'd0);
						cnt = 2'd1; mode_d = stt_pkg::M_IDLE;
					end else if (b != 8'h0a) begin taken = 1'b1; len_d = len_inc; end
					else fin = 1'b1;
				end
				stt_pkg::M_INT: begin
					phase_d = 2'd0;
					if (phase_q == 2'd1 && (b == 8'h78 || b == 8'h58)) begin
						hex_d = 1'b1; taken = 1'b1; len_d = len_inc;
					end else if (b == 8'h5f) begin taken = 1'b1; len_d = len_inc; end
					else if (hex_q && hexc) begin
						taken = 1'b1; len_d = len_inc; acc_d = {acc_q[59:0], hv};
					end else if (!hex_q && dig) begin
						taken = 1'b1; len_d = len_inc;
						acc_d = {acc_q[60:0], 3'd0} + {acc_q[62:0], 1'b0} + 64'(b[3:0]);
					end else fin = 1'b1;
				end
				stt_pkg::M_LABEL: if (dig) begin
					taken = 1'b1; len_d = len_inc;
					acc_d = {acc_q[60:0], 3'd0} + {acc_q[62:0], 1'b0} + 64'(b[3:0]);
				end else fin = 1'b1;
				stt_pkg::M_VAR: if (idch || b == 8'h2e) begin taken = 1'b1; len_d = len_inc; end
					else fin = 1'b1;
				stt_pkg::M_IDENT: if (idch) begin taken = 1'b1; len_d = len_inc; end
					else fin = 1'b1;
				stt_pkg::M_COMMENT: if (b != 8'h0a) taken = 1'b1; else fin = 1'b1;
				default: taken = 1'b0;
			endcase
			if (fin) begin
				mode_d = stt_pkg::M_IDLE;
				if (fe) begin t0 = ft; cnt = 2'd1; end
			end
			// start a new token
			if (!taken && (mode_q == stt_pkg::M_IDLE || fin)) begin
				stt_pkg::token_t nt;
				tstart_d = pos_q; tline_d = line_q; tcol_d = col_q; len_d = 16'd1;
				acc_d = 64'd0; phase_d = 2'd0; esc_d = 1'b0; hex_d = 1'b0;
				nt = mk(stt_pkg::K_OTHER, pos_q, 16'd1, line_q, col_q, {56'd0, b});
				if (b == 8'h20) mode_d = stt_pkg::M_SPACE;
				else if (b == 8'h0a) begin nt.kind = stt_pkg::K_EOL; nt.value = 64'd0; end
				else if (b == 8'h27) begin mode_d = stt_pkg::M_CHAR; phase_d = 2'd1; end
				else if (b == 8'h22) mode_d = stt_pkg::M_STRING;
				else if (b == 8'h3b) mode_d = stt_pkg::M_COMMENT;
				else if (dig) begin
					mode_d = stt_pkg::M_INT; acc_d = 64'(b[3:0]);
					phase_d = (b == 8'h30) ? 2'd1 : 2'd0;
				end else if (b == 8'h40) mode_d = stt_pkg::M_LABEL;
				else if (b == 8'h24 || b == 8'h25) begin mode_d = stt_pkg::M_VAR; held_d = b; end
				else if (alpha) mode_d = stt_pkg::M_IDENT;
				if (b == 8'h0a || mode_d == stt_pkg::M_IDLE) begin
					if (cnt == 2'd1) t1 = nt; else t0 = nt;
					cnt = cnt + 2'd1;
				end
			end
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::M_IDLE; phase_q <= '0; esc_q <= 1'b0; hex_q <= 1'b0;
			held_q <= '0; acc_q <= '0; tstart_q <= '0; len_q <= '0;
			tline_q <= 24'd1; tcol_q <= 16'd1; pos_q <= '0; line_q <= 24'd1; col_q <= 16'd1;
			valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_q <= cnt != 2'd0;
			else if (pair_ready) valid_q <= 1'b0;
			if (in_valid && in_ready) begin
				pair_q.two <= cnt == 2'd2;
				pair_q.first <= t0;
				pair_q.second <= t1;
				if (is_end) begin
					mode_q <= stt_pkg::M_IDLE; phase_q <= '0; esc_q <= 1'b0; hex_q <= 1'b0;
					held_q <= '0; acc_q <= '0; tstart_q <= '0; len_q <= '0;
					tline_q <= 24'd1; tcol_q <= 16'd1; pos_q <= '0;
					line_q <= 24'd1; col_q <= 16'd1;
				end else begin
					mode_q <= mode_d; phase_q <= phase_d; esc_q <= esc_d; hex_q <= hex_d;
					held_q <= held_d; acc_q <= acc_d; tstart_q <= tstart_d; len_q <= len_d;
					tline_q <= tline_d; tcol_q <= tcol_d; pos_q <= pos_q + 1'b1;
					if (b == 8'h0a) begin
						if (line_q != '1) line_q <= line_q + 1'b1;
						col_q <= 16'd1;
					end else if (col_q != '1) col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: design/stt_emit.sv
module stt_emit (
	input logic clk,
	input logic arst_n,
	input logic pair_valid,
	output logic pair_ready,
	input stt_pkg::pair_t pair,
	output logic tok_valid,
	input logic tok_ready,
	output stt_pkg::token_t tok
);

	stt_pkg::pair_t q0_q, q1_q;
	logic [1:0] cnt_q;
	logic sel_q;

	// two-entry queue, drained one token at a time
	assign pair_ready = cnt_q != 2'd2;
	assign tok_valid = cnt_q != 2'd0;
	always_comb begin
		if (sel_q) tok = q0_q.second;
		else tok = q0_q.first;
		tok.last = sel_q || !q0_q.two;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; sel_q <= 1'b0;
		end else begin
			logic pop, push, to_head;
			pop = tok_valid && tok_ready && (sel_q || !q0_q.two);
			push = pair_valid && pair_ready;
			to_head = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
			if (tok_valid && tok_ready) sel_q <= !pop;
			if (push && to_head) q0_q <= pair;
			else if (pop) q0_q <= q1_q;
			if (push && !to_head) q1_q <= pair;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
